FILE: rtl/ffsa_pkg.sv
package ffsa_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_ZERO      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Request kinds
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam int SIZE_W = 18;
  localparam int ADDR_W = 17;

  // Datapath operations issued by the controller
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_SCAN       = 4'd2;
  localparam op_t OP_MARK       = 4'd3;
  localparam op_t OP_SHIFT_INIT = 4'd4;
  localparam op_t OP_SHIFT      = 4'd5;
  localparam op_t OP_SPLIT      = 4'd6;
  localparam op_t OP_MERGE_INIT = 4'd7;
  localparam op_t OP_MERGE      = 4'd8;

  // Datapath status seen by the controller
  typedef struct packed {
    logic              is_release;
    logic              zero_size;
    logic              fit_hit;
    logic              addr_hit;
    logic              last;
    logic              exact;
    logic              full;
    logic              shift_done;
    logic              merge_end;
    logic [ADDR_W-1:0] region;
  } dp_stat_t;

endpackage

FILE: rtl/ffsa_dp.sv
module ffsa_dp #(
  parameter int ARENA_BYTES  = 131072,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ffsa_pkg::op_t             op,
  input  logic                      req_type,
  input  logic [ffsa_pkg::SIZE_W-1:0] alloc_size,
  input  logic [ffsa_pkg::ADDR_W-1:0] free_addr,
  output ffsa_pkg::dp_stat_t        stat
);

  localparam int AW = $clog2(ARENA_BYTES + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = (AW > ffsa_pkg::SIZE_W) ? AW : ffsa_pkg::SIZE_W;

  // Segment table entries 1..MAX-1: start offset above, used bit at bit 0.
  // Entry 0 always starts at zero and keeps its used bit in a flop.
  logic [AW:0] mem [MAX_SEGMENTS];
  logic [AW:0] rd_q;
  logic        we;
  logic [IW-1:0] wa, ra;
  logic [AW:0] wd;

  logic                      req_r;
  logic [ffsa_pkg::SIZE_W-1:0] size_r;
  logic [ffsa_pkg::ADDR_W-1:0] addr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wp_r, wp_nxt;
  logic [IW-1:0] fit_idx_r, fit_idx_nxt;
  logic [AW-1:0] fit_start_r, fit_start_nxt;
  logic [AW-1:0] prev_start_r, prev_start_nxt;
  logic          prev_use_r, prev_use_nxt;
  logic          exact_r, exact_nxt;
  logic          use0_r, use0_nxt;
  logic          last_use_r, last_use_nxt;

  logic [CW-1:0] idx_inc;
  logic [CW:0]   idx_inc2;
  logic [AW-1:0] cur_start;
  logic [AW-1:0] seg_len;
  logic          fit_hit, addr_hit, exact_now, merge_use;

  // Scan compare on the current segment pair
  assign idx_inc   = idx_r + CW'(1);
  assign idx_inc2  = {1'b0, idx_r} + (CW+1)'(2);
  assign cur_start = (idx_inc == count_r) ? AW'(ARENA_BYTES) : rd_q[AW:1];
  assign seg_len   = cur_start - prev_start_r;
  assign fit_hit   = !prev_use_r && (SW'(size_r) <= SW'(seg_len));
  assign exact_now = (SW'(size_r) == SW'(seg_len));
  assign addr_hit  = (SW'(addr_r) == SW'(prev_start_r));
  assign merge_use = (idx_r[IW-1:0] == fit_idx_r) ? 1'b0 : rd_q[0];

  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    wp_nxt         = wp_r;
    fit_idx_nxt    = fit_idx_r;
    fit_start_nxt  = fit_start_r;
    prev_start_nxt = prev_start_r;
    prev_use_nxt   = prev_use_r;
    exact_nxt      = exact_r;
    use0_nxt       = use0_r;
    last_use_nxt   = last_use_r;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = '0;
    unique case (op)
      ffsa_pkg::OP_LOAD: begin
        idx_nxt        = '0;
        prev_start_nxt = '0;
        prev_use_nxt   = use0_r;
        ra             = IW'(1);
      end
      ffsa_pkg::OP_SCAN: begin
        ra             = idx_inc2[IW-1:0];
        prev_start_nxt = cur_start;
        prev_use_nxt   = rd_q[0];
        idx_nxt        = idx_inc;
        if (req_r ? addr_hit : fit_hit) begin
          fit_idx_nxt   = idx_r[IW-1:0];
          fit_start_nxt = prev_start_r;
          exact_nxt     = exact_now;
        end
      end
      ffsa_pkg::OP_MARK: begin
        if (fit_idx_r == '0) begin
          use0_nxt = 1'b1;
        end else begin
          we = 1'b1;
          wa = fit_idx_r;
          wd = {fit_start_r, 1'b1};
        end
      end
      ffsa_pkg::OP_SHIFT_INIT: begin
        idx_nxt = count_r;
        ra      = IW'(count_r - CW'(1));
      end
      ffsa_pkg::OP_SHIFT: begin
        // Move entry idx-1 up to idx, fetch the one below
        we      = 1'b1;
        wa      = idx_r[IW-1:0];
        wd      = rd_q;
        idx_nxt = idx_r - CW'(1);
        ra      = IW'(idx_r - CW'(2));
      end
      ffsa_pkg::OP_SPLIT: begin
        we        = 1'b1;
        wa        = fit_idx_r + IW'(1);
        wd        = {fit_start_r + AW'(size_r), 1'b0};
        count_nxt = count_r + CW'(1);
      end
      ffsa_pkg::OP_MERGE_INIT: begin
        if (fit_idx_r == '0) begin
          use0_nxt = 1'b0;
        end
        last_use_nxt = (fit_idx_r == '0) ? 1'b0 : use0_r;
        idx_nxt      = CW'(1);
        wp_nxt       = CW'(1);
        ra           = IW'(1);
      end
      ffsa_pkg::OP_MERGE: begin
        if (idx_r == count_r) begin
          count_nxt = wp_r;
        end else begin
          // Drop a free entry that follows a free one
          if (merge_use || last_use_r) begin
            we           = 1'b1;
            wa           = wp_r[IW-1:0];
            wd           = {rd_q[AW:1], merge_use};
            wp_nxt       = wp_r + CW'(1);
            last_use_nxt = merge_use;
          end
          idx_nxt = idx_inc;
          ra      = idx_inc[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Segment table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (op == ffsa_pkg::OP_LOAD) begin
      req_r  <= req_type;
      size_r <= alloc_size;
      addr_r <= free_addr;
    end
    fit_idx_r    <= fit_idx_nxt;
    fit_start_r  <= fit_start_nxt;
    prev_start_r <= prev_start_nxt;
    prev_use_r   <= prev_use_nxt;
    exact_r      <= exact_nxt;
    last_use_r   <= last_use_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
      use0_r  <= 1'b0;
      idx_r   <= '0;
      wp_r    <= '0;
    end else begin
      count_r <= count_nxt;
      use0_r  <= use0_nxt;
      idx_r   <= idx_nxt;
      wp_r    <= wp_nxt;
    end
  end

  assign stat.is_release = (req_r == ffsa_pkg::REQ_RELEASE);
  assign stat.zero_size  = (size_r == '0);
  assign stat.fit_hit    = fit_hit;
  assign stat.addr_hit   = addr_hit;
  assign stat.last       = (idx_inc == count_r);
  assign stat.exact      = exact_r;
  assign stat.full       = (count_r == CW'(MAX_SEGMENTS));
  assign stat.shift_done = (idx_r == (CW'(fit_idx_r) + CW'(1)));
  assign stat.merge_end  = (idx_r == count_r);
  assign stat.region     = ffsa_pkg::ADDR_W'(fit_start_r);

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_shift_above_fit: assert property (@(posedge clk) disable iff (!rst_n)
    op == ffsa_pkg::OP_SHIFT |-> idx_r > (CW'(fit_idx_r) + CW'(1)))
    else $error("shift moved below the split point");
  a_merge_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    op == ffsa_pkg::OP_MERGE |-> wp_r <= idx_r)
    else $error("merge write pointer passed read pointer");
`endif

endmodule

FILE: rtl/ffsa_ctrl.sv
module ffsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2:0]         out_status,
  output logic [ffsa_pkg::ADDR_W-1:0] out_region,
  output ffsa_pkg::op_t      op,
  input  ffsa_pkg::dp_stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_MARK   = 4'd4;
  localparam logic [3:0] S_MINIT  = 4'd5;
  localparam logic [3:0] S_MERGE  = 4'd6;
  localparam logic [3:0] S_RESP   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [2:0] code_r, code_nxt;
  logic       with_addr_r, with_addr_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [ffsa_pkg::ADDR_W-1:0] out_region_r, out_region_nxt;
  logic       accept, slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Sequence one request
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    with_addr_nxt = with_addr_r;
    op            = ffsa_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op        = ffsa_pkg::OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        with_addr_nxt = 1'b0;
        if (!stat.is_release && stat.zero_size) begin
          code_nxt  = ffsa_pkg::ST_ZERO;
          state_nxt = S_RESP;
        end else begin
          op = ffsa_pkg::OP_SCAN;
          if (stat.is_release) begin
            if (stat.addr_hit) begin
              state_nxt = S_MINIT;
            end else if (stat.last) begin
              code_nxt  = ffsa_pkg::ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
          end else begin
            if (stat.fit_hit) begin
              state_nxt = S_DECIDE;
            end else if (stat.last) begin
              code_nxt  = ffsa_pkg::ST_NO_FIT;
              state_nxt = S_RESP;
            end
          end
        end
      end
      S_DECIDE: begin
        priority if (stat.exact) begin
          op            = ffsa_pkg::OP_MARK;
          code_nxt      = ffsa_pkg::ST_OK;
          with_addr_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else if (stat.full) begin
          code_nxt  = ffsa_pkg::ST_FULL;
          state_nxt = S_RESP;
        end else begin
          op        = ffsa_pkg::OP_SHIFT_INIT;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          op        = ffsa_pkg::OP_SPLIT;
          state_nxt = S_MARK;
        end else begin
          op = ffsa_pkg::OP_SHIFT;
        end
      end
      S_MARK: begin
        op            = ffsa_pkg::OP_MARK;
        code_nxt      = ffsa_pkg::ST_OK;
        with_addr_nxt = 1'b1;
        state_nxt     = S_RESP;
      end
      S_MINIT: begin
        op        = ffsa_pkg::OP_MERGE_INIT;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        op = ffsa_pkg::OP_MERGE;
        if (stat.merge_end) begin
          code_nxt  = ffsa_pkg::ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load the result, hold until taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_region_nxt = out_region_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_RESP && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = code_r;
      out_region_nxt = with_addr_r ? stat.region : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    with_addr_r  <= with_addr_nxt;
    out_status_r <= out_status_nxt;
    out_region_r <= out_region_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_region = out_region_r;

`ifndef SYNTHESIS
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accepted request did not start a scan");
  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && slot_free) |=> out_tvalid && state_r == S_IDLE)
    else $error("result not presented on leaving response state");
`endif

endmodule

FILE: rtl/first_fit_segment_allocator_core.sv
// First-fit segment allocator: keeps the arena as an address-ordered table of
// up to MAX_SEGMENTS segments held in a single-port-write, registered-read
// memory. One request is handled at a time; each gives exactly one result.
// An allocate marks the first fitting segment in place when the fit is exact,
// and otherwise shifts the table up to split it; a release searches for the
// address, then makes a merge pass over the whole table. The memory port
// moves one entry per cycle, and a request waits in its response state while
// the output register is stalled.
// A result waits in an output register, so the next request is taken as soon
// as the previous one has been handed to that register.
module first_fit_segment_allocator_core #(
  parameter int ARENA_BYTES  = 131072,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // alloc_size[17:0], free_addr[34:18], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[2:0], region_addr[19:3], zero pad
);

  ffsa_pkg::op_t      op;
  ffsa_pkg::dp_stat_t stat;
  logic [2:0]         status;
  logic [ffsa_pkg::ADDR_W-1:0] region;

  ffsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (status),
    .out_region (region),
    .op         (op),
    .stat       (stat)
  );

  ffsa_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .req_type   (in_tuser),
    .alloc_size (in_tdata[17:0]),
    .free_addr  (in_tdata[34:18]),
    .stat       (stat)
  );

  assign out_tdata = {4'b0, region, status};

endmodule
